>>> hw/rtl/darg_pkg.sv
// Shared types and constants of the asymmetric ramp frequency governor.
// Holds register indexes, reset values, field widths and the divide-by-100 constants.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package darg_pkg;

    localparam int PCT_W    = 7;
    localparam int FREQ_W   = 24;
    localparam int STEP_W   = 25;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = PCT_W + FREQ_W;
    localparam int DIVN_W   = PROD_W - 2;
    localparam int RECIP_W  = 30;
    localparam int RECIP_SH = 34;

    // The product pct * max_freq is divided by 4 with a shift and then by 25 with
    // a reciprocal multiply that is exact for every dividend below 2**29.
    localparam logic [RECIP_W-1:0] RECIP_DIV25 = 30'd687194768;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_UP_THRESHOLD   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DOWN_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_IDEAL_FREQ     = 3'd2;
    localparam logic [IDX_W-1:0] REG_UP_STEP_PCT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOWN_STEP_PCT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN_FREQ       = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_FREQ       = 3'd6;

    // Reset values of the registers.
    localparam logic [PCT_W-1:0]  RST_UP_THRESHOLD   = 7'd75;
    localparam logic [PCT_W-1:0]  RST_DOWN_THRESHOLD = 7'd30;
    localparam logic [FREQ_W-1:0] RST_IDEAL_FREQ     = 24'd0;
    localparam logic [PCT_W-1:0]  RST_UP_STEP_PCT    = 7'd15;
    localparam logic [PCT_W-1:0]  RST_DOWN_STEP_PCT  = 7'd5;
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ       = 24'd300000;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ       = 24'd2000000;

    // Cycles from a register write until the step sizes are valid again.
    localparam int                 STEP_LAT_W = 2;
    localparam logic [STEP_LAT_W-1:0] STEP_LATENCY = 2'd2;

    typedef struct packed {
        logic [STEP_W-1:0] up;
        logic [STEP_W-1:0] dn;
        logic              busy;
    } t_steps;

endpackage

`default_nettype wire

>>> hw/rtl/dvfs_asymmetric_ramp_governor_top.sv
// Asymmetric ramp frequency governor: one load sample in, one frequency request out.
// Instantiates darg_step_calc; depends on darg_pkg.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   in      | i_in_valid / o_in_ready   | i_load_pct, i_current_freq
//   out     | o_out_valid / i_out_ready | o_request_valid, o_target_freq, o_round_down
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A sample is taken every cycle while o_in_ready is high; its result is registered.
// The only loop is last_request, updated in the same cycle the result register loads.
// After reset and after each register write, o_in_ready stays low while the step
// multiply and the reciprocal divide by 100 run again.
// A stalled output holds the input register; a new sample enters as the old one leaves.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_asymmetric_ramp_governor_top
    import darg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [PCT_W-1:0]  i_load_pct,
    input  wire logic [FREQ_W-1:0] i_current_freq,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_request_valid,
    output logic [FREQ_W-1:0]      o_target_freq,
    output logic                   o_round_down,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [FREQ_W-1:0] i_cfg_data
);

    logic [PCT_W-1:0]  r_up_threshold, r_down_threshold, r_up_step_pct, r_down_step_pct;
    logic [FREQ_W-1:0] r_ideal_freq, r_min_freq, r_max_freq;
    logic              cfg_wr;
    t_steps            steps;

    logic              r_in_valid;
    logic [PCT_W-1:0]  r_load;
    logic [FREQ_W-1:0] r_cur;
    logic [FREQ_W-1:0] r_last_request, n_last_request;

    logic              r_out_valid;
    logic              r_request_valid, n_request_valid;
    logic [FREQ_W-1:0] r_target_freq, n_target_freq;
    logic              r_round_down, n_round_down;

    logic              out_load, advance, in_accept;
    logic              stale, go_up, go_dn, ideal_ok, valid_up, valid_dn;
    logic [FREQ_W-1:0] req, up_target, dn_target;
    logic [STEP_W:0]   up_sum;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_threshold   <= RST_UP_THRESHOLD;
            r_down_threshold <= RST_DOWN_THRESHOLD;
            r_ideal_freq     <= RST_IDEAL_FREQ;
            r_up_step_pct    <= RST_UP_STEP_PCT;
            r_down_step_pct  <= RST_DOWN_STEP_PCT;
            r_min_freq       <= RST_MIN_FREQ;
            r_max_freq       <= RST_MAX_FREQ;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_UP_THRESHOLD:   r_up_threshold   <= i_cfg_data[PCT_W-1:0];
                REG_DOWN_THRESHOLD: r_down_threshold <= i_cfg_data[PCT_W-1:0];
                REG_IDEAL_FREQ:     r_ideal_freq     <= i_cfg_data;
                REG_UP_STEP_PCT:    r_up_step_pct    <= i_cfg_data[PCT_W-1:0];
                REG_DOWN_STEP_PCT:  r_down_step_pct  <= i_cfg_data[PCT_W-1:0];
                REG_MIN_FREQ:       r_min_freq       <= i_cfg_data;
                REG_MAX_FREQ:       r_max_freq       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    darg_step_calc u_step_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cfg_wr),
        .i_up_pct   (r_up_step_pct),
        .i_dn_pct   (r_down_step_pct),
        .i_max_freq (r_max_freq),
        .o_steps    (steps)
    );

    // Flow control between the input and result registers.
    assign out_load   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_load;
    assign o_in_ready = (!r_in_valid || out_load) && !steps.busy;
    assign in_accept  = i_in_valid && o_in_ready;

    // Decision logic for the sample in the input register.
    always_comb begin
        stale     = (r_last_request > r_max_freq) || (r_last_request < r_min_freq);
        req       = stale ? r_cur : r_last_request;
        go_up     = r_load > r_up_threshold;
        go_dn     = r_load < r_down_threshold;
        ideal_ok  = (r_ideal_freq > r_min_freq) && (r_ideal_freq <= r_max_freq)
                    && (req < r_ideal_freq);
        up_sum    = (STEP_W+1)'(req) + (STEP_W+1)'(steps.up);
        if (ideal_ok) begin
            up_target = r_ideal_freq;
        end else if (up_sum > (STEP_W+1)'(r_max_freq)) begin
            up_target = r_max_freq;
        end else begin
            up_target = up_sum[FREQ_W-1:0];
        end
        if (STEP_W'(req) > steps.dn) begin
            dn_target = req - steps.dn[FREQ_W-1:0];
        end else begin
            dn_target = r_min_freq;
        end
        valid_up  = go_up && (req != r_max_freq);
        valid_dn  = !go_up && go_dn && (req != r_min_freq);

        n_request_valid = valid_up || valid_dn;
        n_round_down    = valid_up;
        if (valid_up) begin
            n_target_freq = up_target;
        end else if (valid_dn) begin
            n_target_freq = dn_target;
        end else begin
            n_target_freq = '0;
        end
        n_last_request = n_request_valid ? n_target_freq : req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_last_request <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_last_request <= n_last_request;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_load <= i_load_pct;
            r_cur  <= i_current_freq;
        end
        if (advance) begin
            r_request_valid <= n_request_valid;
            r_target_freq   <= n_target_freq;
            r_round_down    <= n_round_down;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_request_valid = r_request_valid;
    assign o_target_freq   = r_target_freq;
    assign o_round_down    = r_round_down;

endmodule

`default_nettype wire

>>> hw/rtl/darg_step_calc.sv
// Step size precompute: (pct * max_freq) / 100, at least 1, for both ramp directions.
// Two registered stages (multiply, reciprocal divide) plus a busy countdown.
// Depends on darg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module darg_step_calc
    import darg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PCT_W-1:0]  i_up_pct,
    input  wire logic [PCT_W-1:0]  i_dn_pct,
    input  wire logic [FREQ_W-1:0] i_max_freq,
    output t_steps                 o_steps
);

    logic [PROD_W-1:0]          r_prod_up, r_prod_dn;
    logic [STEP_W-1:0]          r_step_up, r_step_dn;
    logic [STEP_LAT_W-1:0]      r_cnt, n_cnt;
    logic [DIVN_W+RECIP_W-1:0]  quot_up_full, quot_dn_full;
    logic [STEP_W-1:0]          quot_up, quot_dn;

    assign quot_up_full = r_prod_up[PROD_W-1:2] * RECIP_DIV25;
    assign quot_dn_full = r_prod_dn[PROD_W-1:2] * RECIP_DIV25;
    assign quot_up      = quot_up_full[RECIP_SH +: STEP_W];
    assign quot_dn      = quot_dn_full[RECIP_SH +: STEP_W];

    always_ff @(posedge i_clk) begin
        r_prod_up <= PROD_W'(i_up_pct) * PROD_W'(i_max_freq);
        r_prod_dn <= PROD_W'(i_dn_pct) * PROD_W'(i_max_freq);
        r_step_up <= (quot_up == '0) ? STEP_W'(1) : quot_up;
        r_step_dn <= (quot_dn == '0) ? STEP_W'(1) : quot_dn;
    end

    always_comb begin
        if (i_start) begin
            n_cnt = STEP_LATENCY;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Reset also starts a pass so that the steps of the reset values get computed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= STEP_LATENCY;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_steps.up   = r_step_up;
    assign o_steps.dn   = r_step_dn;
    assign o_steps.busy = (r_cnt != '0);

endmodule

`default_nettype wire

>>> hw/rtl/darg_checker.sv
// Port-level checks for the asymmetric ramp frequency governor.
// Bound to dvfs_asymmetric_ramp_governor_top; depends on darg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module darg_checker
    import darg_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_request_valid,
    input wire logic [FREQ_W-1:0] o_target_freq,
    input wire logic              o_round_down,
    input wire logic              i_cfg_valid,
    input wire logic              o_cfg_ready
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result register not empty after reset");

    // A result without a request carries zero fields.
    a_no_request_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_request_valid) |-> (o_target_freq == '0 && !o_round_down))
        else $error("no-request result with nonzero fields");

    // The step sizes are recomputed after a register write, so no sample enters then.
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_in_ready)
        else $error("sample channel ready right after a register write");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_request_valid) && $stable(o_target_freq)
             && $stable(o_round_down)))
        else $error("stalled result changed");

endmodule

bind dvfs_asymmetric_ramp_governor_top darg_checker u_darg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_request_valid (o_request_valid),
    .o_target_freq   (o_target_freq),
    .o_round_down    (o_round_down),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready)
);

`default_nettype wire

>>> dv/tb_dvfs_asymmetric_ramp_governor_top.sv
// Self-checking testbench for dvfs_asymmetric_ramp_governor_top: a scoreboard class predicts
// each frequency request and compares it with the output channel.
// Depends on darg_pkg and the governor RTL; needs no files or arguments.
`timescale 1ns / 1ps

import darg_pkg::*;

class freq_request_board;
    typedef struct {
        bit        req_valid;
        bit [23:0] target;
        bit        rdown;
    } t_request;

    bit [6:0]  up_thr;
    bit [6:0]  down_thr;
    bit [6:0]  up_pct;
    bit [6:0]  down_pct;
    bit [23:0] ideal;
    bit [23:0] min_freq;
    bit [23:0] max_freq;
    bit [23:0] last_req;
    t_request  pending_requests[$];
    int        mismatches;

    function new();
        up_thr     = RST_UP_THRESHOLD;
        down_thr   = RST_DOWN_THRESHOLD;
        ideal      = RST_IDEAL_FREQ;
        up_pct     = RST_UP_STEP_PCT;
        down_pct   = RST_DOWN_STEP_PCT;
        min_freq   = RST_MIN_FREQ;
        max_freq   = RST_MAX_FREQ;
        last_req   = '0;
        mismatches = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [23:0] data);
        case (idx)
            REG_UP_THRESHOLD:   up_thr = data[6:0];
            REG_DOWN_THRESHOLD: down_thr = data[6:0];
            REG_IDEAL_FREQ:     ideal = data;
            REG_UP_STEP_PCT:    up_pct = data[6:0];
            REG_DOWN_STEP_PCT:  down_pct = data[6:0];
            REG_MIN_FREQ:       min_freq = data;
            REG_MAX_FREQ:       max_freq = data;
            default: ;
        endcase
    endfunction

    // The step is a percentage of max_freq, truncated, but never zero.
    function bit [31:0] step_size(bit [6:0] pct);
        bit [63:0] s;
        s = (64'(pct) * 64'(max_freq)) / 64'd100;
        if (s == 0)
            s = 1;
        return s[31:0];
    endfunction

    function void take_sample(bit [6:0] load, bit [23:0] cur);
        t_request  r;
        bit [31:0] req;
        bit [31:0] s;
        req = {8'd0, last_req};
        // A remembered request outside the limits is replaced even without a new request.
        if (req > max_freq || req < min_freq) begin
            req = {8'd0, cur};
            last_req = cur;
        end
        r = '{1'b0, 24'd0, 1'b0};
        if (load > up_thr) begin
            if (req != max_freq) begin
                if (ideal > min_freq && ideal <= max_freq && req < ideal) begin
                    req = {8'd0, ideal};
                end else begin
                    req = req + step_size(up_pct);
                    if (req > max_freq)
                        req = {8'd0, max_freq};
                end
                r = '{1'b1, req[23:0], 1'b1};
            end
        end else if (load < down_thr) begin
            if (req != min_freq) begin
                s = step_size(down_pct);
                req = (req > s) ? req - s : {8'd0, min_freq};
                r = '{1'b1, req[23:0], 1'b0};
            end
        end
        if (r.req_valid)
            last_req = r.target;
        pending_requests.push_back(r);
    endfunction

    function void match_request(bit v, bit [23:0] t, bit rd);
        t_request e;
        if (pending_requests.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: request_valid=%0d target_freq=%0d round_down=%0d",
                         v, t, rd);
            return;
        end
        e = pending_requests.pop_front();
        if (e.req_valid != v || e.target != t || e.rdown != rd) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected valid=%0d target=%0d round_down=%0d, got %0d %0d %0d",
                         e.req_valid, e.target, e.rdown, v, t, rd);
        end
    endfunction
endclass

module tb_dvfs_asymmetric_ramp_governor_top;

    localparam int              CYCLE_LIMIT = 400000;
    localparam int              PHASE_ITEMS = 250;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [PCT_W-1:0]  i_load_pct;
    logic [FREQ_W-1:0] i_current_freq;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_request_valid;
    logic [FREQ_W-1:0] o_target_freq;
    logic              o_round_down;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [FREQ_W-1:0] i_cfg_data;

    freq_request_board sb;
    bit                steady;
    int                cycle_count;

    dvfs_asymmetric_ramp_governor_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_load_pct     (i_load_pct),
        .i_current_freq (i_current_freq),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_request_valid(o_request_valid),
        .o_target_freq  (o_target_freq),
        .o_round_down   (o_round_down),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dvfs_asymmetric_ramp_governor_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.match_request(o_request_valid, o_target_freq, o_round_down);
    end

    // Valid is left high after the transaction; the next call lowers it only to idle.
    task automatic send_sample(input logic [6:0] load, input logic [23:0] cur);
        while (!steady && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_load_pct     <= load;
        i_current_freq <= cur;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(load, cur);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_requests.size() != 0);
    endtask

    task automatic quiesce();
        drain_requests();
        repeat (4) @(posedge i_clk);
    endtask

    // Random noise above bit 6 checks that the 7-bit registers ignore it.
    function automatic logic [23:0] pad_pct(input logic [6:0] v);
        return {17'($urandom()), v};
    endfunction

    function automatic logic [23:0] pick_freq();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return 24'($urandom());
        if (sel < 18)
            return sb.min_freq;
        if (sel < 24)
            return sb.max_freq;
        return 24'($urandom_range(sb.max_freq, sb.min_freq));
    endfunction

    function automatic logic [6:0] pick_load(input int mode);
        int lo;
        int hi;
        case (mode)
            0, 1: begin
                lo = sb.up_thr + 1;
                hi = (lo <= 100 && $urandom_range(7) != 0) ? 100 : 127;
                return (lo > 127) ? 7'd127 : 7'($urandom_range(hi, lo));
            end
            2, 3: return (sb.down_thr == 0) ? 7'd0 : 7'($urandom_range(sb.down_thr - 1, 0));
            4:    return 7'($urandom_range(100, 0));
            default: return 7'($urandom_range(127, 0));
        endcase
    endfunction

    task automatic run_directed();
        // Reset settings: the first sample replaces the cleared request by the clock.
        send_sample(7'd50, 24'd1000000);
        send_sample(7'd127, 24'd0);
        send_sample(7'd0, 24'd16777215);
        send_sample(7'd76, 24'd5);
        send_sample(7'd100, 24'd5);
        send_sample(7'd100, 24'd5);
        send_sample(7'd100, 24'd5);
        send_sample(7'd75, 24'd5);
        send_sample(7'd30, 24'd5);
        send_sample(7'd29, 24'd5);
        // A large down step drops the request below min_freq, which then goes stale.
        quiesce();
        cfg_write(REG_MIN_FREQ, 24'd1000000);
        cfg_write(REG_DOWN_STEP_PCT, pad_pct(7'd30));
        i_cfg_valid <= 1'b0;
        send_sample(7'd0, 24'd5);
        send_sample(7'd0, 24'd5);
        send_sample(7'd50, 24'd1234567);
        send_sample(7'd0, 24'd5);
        // A step at least as big as the request floors to min_freq.
        quiesce();
        cfg_write(REG_DOWN_STEP_PCT, pad_pct(7'd100));
        i_cfg_valid <= 1'b0;
        send_sample(7'd0, 24'd1500000);
        send_sample(7'd0, 24'd5);
        quiesce();
        cfg_write(REG_IDEAL_FREQ, 24'd1700000);
        i_cfg_valid <= 1'b0;
        send_sample(7'd127, 24'd5);
        send_sample(7'd127, 24'd5);
        // Overlapping thresholds: the up test wins.
        quiesce();
        cfg_write(REG_UP_THRESHOLD, pad_pct(7'd10));
        cfg_write(REG_DOWN_THRESHOLD, pad_pct(7'd90));
        i_cfg_valid <= 1'b0;
        send_sample(7'd50, 24'd5);
        send_sample(7'd5, 24'd5);
        send_sample(7'd50, 24'd5);
    endtask

    task automatic program_phase(input int kind);
        logic [6:0]  ut;
        logic [6:0]  dt;
        logic [6:0]  ups;
        logic [6:0]  dns;
        logic [23:0] idl;
        logic [23:0] mn;
        logic [23:0] mx;
        int unsigned span;
        mn   = 24'($urandom_range(1000000, 1));
        span = $urandom_range(4000000, 1);
        mx   = (mn + span > 16777215) ? 24'd16777215 : 24'(mn + span);
        ut   = 7'($urandom_range(95, 50));
        dt   = 7'($urandom_range(45, 5));
        ups  = 7'($urandom_range(100, 1));
        dns  = 7'($urandom_range(100, 1));
        idl  = $urandom_range(1) ? 24'($urandom_range(mx, mn)) : 24'd0;
        case (kind)
            1: begin
                ut = 7'd1; dt = 7'd99; ups = 7'd100; dns = 7'd100;
                idl = 24'd16777215; mn = 24'd1; mx = 24'd16777215;
            end
            2: begin
                ut = 7'd100; dt = 7'd1; ups = 7'd1; dns = 7'd1;
                idl = 24'd50; mn = 24'd1; mx = 24'd100;
            end
            3: begin
                ut = 7'($urandom()); dt = 7'($urandom()); ups = 7'($urandom());
                dns = 7'($urandom()); idl = 24'($urandom()); mn = 24'($urandom());
                mx = 24'($urandom());
            end
            5: begin
                ut = 7'd0; dt = 7'd127; ups = 7'd127; dns = 7'd0;
                idl = 24'($urandom()); mn = 24'd0; mx = 24'd16777215;
            end
            default: ;
        endcase
        cfg_write(REG_UP_THRESHOLD, pad_pct(ut));
        cfg_write(REG_DOWN_THRESHOLD, pad_pct(dt));
        cfg_write(REG_IDEAL_FREQ, idl);
        cfg_write(REG_UP_STEP_PCT, pad_pct(ups));
        cfg_write(REG_DOWN_STEP_PCT, pad_pct(dns));
        cfg_write(REG_MIN_FREQ, mn);
        cfg_write(REG_MAX_FREQ, mx);
        cfg_write(REG_UNUSED, 24'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int load_mode;
        int burst_left;
        sb             = new();
        steady         = 1'b0;
        cycle_count    = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_load_pct     = '0;
        i_current_freq = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        load_mode      = 0;
        burst_left     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int ph = 0; ph < 7; ph++) begin
            quiesce();
            program_phase(ph);
            steady = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The sender holds off once until every request is back.
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    drain_requests();
                // Loads come in bursts so the request walks all the way to either limit.
                if (burst_left == 0) begin
                    load_mode  = $urandom_range(5);
                    burst_left = $urandom_range(30, 1);
                end
                burst_left--;
                send_sample(pick_load(load_mode), pick_freq());
            end
            steady = 1'b0;
        end
        quiesce();
        if (sb.mismatches == 0 && sb.pending_requests.size() == 0) begin
            $display("dvfs_asymmetric_ramp_governor_top verification clean");
        end else begin
            $display("dvfs_asymmetric_ramp_governor_top verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/darg_pkg.sv
hw/rtl/darg_step_calc.sv
hw/rtl/dvfs_asymmetric_ramp_governor_top.sv
hw/rtl/darg_checker.sv
dv/tb_dvfs_asymmetric_ramp_governor_top.sv
